// ----- hdl/hfpr_pkg.sv -----
// ----------------------------------------------------------------------------
// hfpr_pkg
// Shared codes, control/status bundles and the CORDIC arctangent table for the
// hint fold phase rotator.
// ----------------------------------------------------------------------------
package hfpr_pkg;

  // action codes carried in s_tuser[1:0]
  localparam logic [1:0] ACT_HINT  = 2'd0;
  localparam logic [1:0] ACT_ELEM  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  // hint kinds carried in s_tuser[3:2]
  localparam logic [1:0] KIND_PERFECT = 2'd0;
  localparam logic [1:0] KIND_MODULAR = 2'd1;
  localparam logic [1:0] KIND_APPROX  = 2'd2;

  // result kinds on m_tuser
  localparam logic RES_ADDR   = 1'b0;
  localparam logic RES_WEIGHT = 1'b1;

  // config register indexes
  localparam logic [1:0] REG_MODULUS    = 2'd0;
  localparam logic [1:0] REG_NUM_COORDS = 2'd1;
  localparam logic [1:0] REG_CONF_THR   = 2'd2;

  // config reset values
  localparam logic [11:0] MODULUS_RST    = 12'd4093;
  localparam logic [8:0]  NUM_COORDS_RST = 9'd256;
  localparam logic [15:0] CONF_THR_RST   = 16'd58983;

  // iteration counts
  localparam logic [5:0] DIV_LAST    = 6'd35;  // 36 quotient bits
  localparam logic [5:0] CORDIC_LAST = 6'd15;  // 16 rotations
  localparam logic [5:0] MUL_LAST    = 6'd3;   // 4 partial products

  // phase in units of 2^-24 turn
  localparam logic signed [26:0] TURN_FULL    = 27'sd16777216;
  localparam logic signed [26:0] TURN_HALF    = 27'sd8388608;
  localparam logic signed [26:0] TURN_QUARTER = 27'sd4194304;

  localparam logic signed [17:0] CORDIC_X0 = 18'sd19898;

  typedef struct packed {
    logic latch_in;
    logic hint_exec;
    logic clear_pins;
    logic elem_exec;
    logic emit_addr;
    logic ld_mod;
    logic ld_t;
    logic ld_rot;
    logic div_step;
    logic cordic_step;
    logic mul_step;
    logic emit_wt;
  } cmd_t;

  typedef struct packed {
    logic elem_pinned;
    logic elem_last;
    logic div_last;
    logic cordic_last;
    logic mul_last;
    logic out_free;
  } stat_t;

  function automatic logic [21:0] atan_turn(input logic [3:0] i);
    logic [21:0] v;
    case (i)
      4'd0:    v = 22'd2097152;
      4'd1:    v = 22'd1238021;
      4'd2:    v = 22'd654136;
      4'd3:    v = 22'd332050;
      4'd4:    v = 22'd166669;
      4'd5:    v = 22'd83416;
      4'd6:    v = 22'd41718;
      4'd7:    v = 22'd20860;
      4'd8:    v = 22'd10430;
      4'd9:    v = 22'd5215;
      4'd10:   v = 22'd2608;
      4'd11:   v = 22'd1304;
      4'd12:   v = 22'd652;
      4'd13:   v = 22'd326;
      4'd14:   v = 22'd163;
      default: v = 22'd81;
    endcase
    return v;
  endfunction

endpackage

// ----- hdl/hfpr_ram.sv -----
// ----------------------------------------------------------------------------
// hfpr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hfpr_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/hfpr_ctrl.sv -----
// ----------------------------------------------------------------------------
// hfpr_ctrl
// Sequencer: accepts transactions and steps the datapath through hint update,
// element fold, residue/phase division, CORDIC and complex multiply.
// ----------------------------------------------------------------------------
module hfpr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic [1:0]       s_action,
  input  hfpr_pkg::stat_t  stat,
  output logic             s_tready,
  output hfpr_pkg::cmd_t   cmd
);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_HINT   = 12'b000000000010,
    S_ELEM   = 12'b000000000100,
    S_EMIT_A = 12'b000000001000,
    S_LD_MOD = 12'b000000010000,
    S_DIV_M  = 12'b000000100000,
    S_LD_T   = 12'b000001000000,
    S_DIV_T  = 12'b000010000000,
    S_LD_ROT = 12'b000100000000,
    S_CORDIC = 12'b001000000000,
    S_MUL    = 12'b010000000000,
    S_EMIT_W = 12'b100000000000
  } state_t;

  state_t state, state_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.latch_in = 1'b1;
          unique case (s_action)
            hfpr_pkg::ACT_HINT:  state_next = S_HINT;
            hfpr_pkg::ACT_ELEM:  state_next = S_ELEM;
            hfpr_pkg::ACT_CLEAR: cmd.clear_pins = 1'b1;
            default:             state_next = S_IDLE;
          endcase
        end
      end
      S_HINT: begin
        cmd.hint_exec = 1'b1;
        state_next    = S_IDLE;
      end
      S_ELEM: begin
        cmd.elem_exec = 1'b1;
        if (!stat.elem_pinned) begin
          state_next = S_EMIT_A;
        end else if (stat.elem_last) begin
          state_next = S_LD_MOD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_EMIT_A: begin
        if (stat.out_free) begin
          cmd.emit_addr = 1'b1;
          state_next    = stat.elem_last ? S_LD_MOD : S_IDLE;
        end
      end
      S_LD_MOD: begin
        cmd.ld_mod = 1'b1;
        state_next = S_DIV_M;
      end
      S_DIV_M: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_next = S_LD_T;
      end
      S_LD_T: begin
        cmd.ld_t   = 1'b1;
        state_next = S_DIV_T;
      end
      S_DIV_T: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_next = S_LD_ROT;
      end
      S_LD_ROT: begin
        cmd.ld_rot = 1'b1;
        state_next = S_CORDIC;
      end
      S_CORDIC: begin
        cmd.cordic_step = 1'b1;
        if (stat.cordic_last) state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        if (stat.mul_last) state_next = S_EMIT_W;
      end
      S_EMIT_W: begin
        if (stat.out_free) begin
          cmd.emit_wt = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- hdl/hfpr_dp.sv -----
// ----------------------------------------------------------------------------
// hfpr_dp
// Datapath: config registers, pin table, phase accumulator, shared restoring
// divider, CORDIC twiddle unit, sequential complex multiplier, output register.
// ----------------------------------------------------------------------------
module hfpr_dp #(
  parameter int MAX_COORDS   = 256,
  parameter int RESIDUE_BITS = 12
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [15:0]      cfg_data,
  input  logic [127:0]     s_tdata,
  input  logic [3:0]       s_tuser,
  input  logic             s_tlast,
  input  hfpr_pkg::cmd_t   cmd,
  output hfpr_pkg::stat_t  stat,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [87:0]      m_tdata,
  output logic             m_tuser,
  output logic             m_tlast
);

  localparam int IW = $clog2(MAX_COORDS);
  localparam int KW = $clog2(MAX_COORDS + 1);
  localparam int CW = (KW > 9) ? KW : 9;
  localparam int DW = (IW > 8) ? IW : 8;
  localparam int VW = (RESIDUE_BITS < 12) ? RESIDUE_BITS : 12;

  // config
  logic [11:0] modulus;
  logic [8:0]  num_coords;
  logic [15:0] conf_threshold;

  // latched transaction
  logic [7:0]         hint_coord;
  logic [1:0]         hint_kind;
  logic [11:0]        hint_modulus;
  logic [11:0]        hint_value;
  logic [15:0]        hint_confidence;
  logic [11:0]        elem_addr;
  logic               elem_last;
  logic signed [31:0] weight_re;
  logic signed [31:0] weight_im;

  // pin state
  logic [MAX_COORDS-1:0] pin_flags;
  logic [KW-1:0]         pin_count;
  logic [KW-1:0]         coord_index;
  logic [33:0]           phase_acc;
  logic [VW-1:0]         pin_rd;

  // effective k and kept count
  logic [CW-1:0] nc_ext;
  logic [CW-1:0] k_ext;
  logic [KW-1:0] k;
  logic [KW-1:0] kept_now;
  logic [8:0]    kept_count;

  always_comb begin
    nc_ext = CW'(num_coords);
    k_ext  = nc_ext;
    if (nc_ext == '0) k_ext = CW'(1);
    if (k_ext > CW'(MAX_COORDS)) k_ext = CW'(MAX_COORDS);
    k        = k_ext[KW-1:0];
    kept_now = (pin_count >= k) ? KW'(1) : (k - pin_count);
    kept_count = 9'(kept_now);
  end

  // hint decision
  logic [DW-1:0] hint_ext;
  logic [IW-1:0] hint_idx;
  logic          hint_ok;
  logic          hint_take;

  always_comb begin
    hint_ext = DW'(hint_coord);
    hint_idx = hint_ext[IW-1:0];
    case (hint_kind)
      hfpr_pkg::KIND_PERFECT: hint_ok = 1'b1;
      hfpr_pkg::KIND_MODULAR: hint_ok = (hint_modulus == modulus);
      hfpr_pkg::KIND_APPROX:
        hint_ok = (hint_confidence != 16'd0) && (hint_confidence >= conf_threshold);
      default:                hint_ok = 1'b0;
    endcase
    hint_take = (CW'(hint_coord) < CW'(k)) && !pin_flags[hint_idx] && hint_ok;
  end

  // element fold
  logic [IW-1:0]   d_idx;
  logic            elem_pinned;
  logic [2*VW-1:0] fold_prod;

  assign d_idx       = coord_index[IW-1:0];
  assign elem_pinned = (coord_index < k) && pin_flags[d_idx] &&
                       !((coord_index == '0) && (pin_count >= k));
  assign fold_prod   = elem_addr[VW-1:0] * pin_rd;

  hfpr_ram #(.WIDTH(VW), .DEPTH(MAX_COORDS)) u_pin_ram (
    .clk   (clk),
    .we    (cmd.hint_exec && hint_take),
    .waddr (hint_idx),
    .wdata (hint_value[VW-1:0]),
    .re    (cmd.latch_in),
    .raddr (d_idx),
    .rdata (pin_rd)
  );

  logic cfg_nc_wr;
  assign cfg_nc_wr = cfg_we && (cfg_index == hfpr_pkg::REG_NUM_COORDS);

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus        <= hfpr_pkg::MODULUS_RST;
      num_coords     <= hfpr_pkg::NUM_COORDS_RST;
      conf_threshold <= hfpr_pkg::CONF_THR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        hfpr_pkg::REG_MODULUS:    modulus        <= cfg_data[11:0];
        hfpr_pkg::REG_NUM_COORDS: num_coords     <= cfg_data[8:0];
        hfpr_pkg::REG_CONF_THR:   conf_threshold <= cfg_data;
        default:                  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      hint_coord      <= s_tdata[7:0];
      hint_modulus    <= s_tdata[19:8];
      hint_value      <= s_tdata[31:20];
      hint_confidence <= s_tdata[47:32];
      elem_addr       <= s_tdata[59:48];
      weight_re       <= s_tdata[91:60];
      weight_im       <= s_tdata[123:92];
      hint_kind       <= s_tuser[3:2];
      elem_last       <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_nc_wr || cmd.clear_pins) begin
      pin_flags <= '0;
      pin_count <= '0;
    end else if (cmd.hint_exec && hint_take) begin
      pin_flags[hint_idx] <= 1'b1;
      pin_count           <= pin_count + KW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_nc_wr) begin
      coord_index <= '0;
      phase_acc   <= '0;
    end else begin
      if (cmd.elem_exec) begin
        if (elem_last) begin
          coord_index <= '0;
        end else if (coord_index < k) begin
          coord_index <= coord_index + KW'(1);
        end
        if (elem_pinned) phase_acc <= phase_acc + 34'(fold_prod);
      end else if (cmd.ld_mod) begin
        phase_acc <= '0;
      end
    end
  end

  // shared step counter
  logic [5:0] cnt;
  logic       step_last;

  always_comb begin
    step_last = 1'b0;
    if (cmd.div_step)    step_last = (cnt == hfpr_pkg::DIV_LAST);
    if (cmd.cordic_step) step_last = (cnt == hfpr_pkg::CORDIC_LAST);
    if (cmd.mul_step)    step_last = (cnt == hfpr_pkg::MUL_LAST);
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.ld_mod || cmd.ld_t || cmd.ld_rot) begin
      cnt <= '0;
    end else if (cmd.div_step || cmd.cordic_step || cmd.mul_step) begin
      cnt <= step_last ? 6'd0 : cnt + 6'd1;
    end
  end

  // restoring divider, one quotient bit per cycle
  logic [11:0] div_rem;
  logic [35:0] div_q;
  logic [11:0] div_p;
  logic [11:0] p_eff;
  logic [11:0] r_eff;
  logic [12:0] div_sh;
  logic [12:0] div_diff;
  logic        div_ge;

  assign p_eff    = (modulus >= 12'd2) ? modulus : 12'd2;
  assign r_eff    = (modulus >= 12'd2) ? div_rem : 12'd0;
  assign div_sh   = {div_rem, div_q[35]};
  assign div_ge   = (div_sh >= {1'b0, div_p});
  assign div_diff = div_sh - {1'b0, div_p};

  always_ff @(posedge clk) begin
    if (cmd.ld_mod) begin
      div_q   <= {2'b00, phase_acc};
      div_rem <= '0;
      div_p   <= p_eff;
    end else if (cmd.ld_t) begin
      div_q   <= {r_eff, 24'd0};
      div_rem <= '0;
    end else if (cmd.div_step) begin
      div_rem <= div_ge ? div_diff[11:0] : div_sh[11:0];
      div_q   <= {div_q[34:0], div_ge};
    end
  end

  // CORDIC twiddle
  logic signed [26:0] t_s;
  logic signed [26:0] ang0;
  logic signed [26:0] ang1;
  logic               fold_neg;
  logic signed [17:0] cx;
  logic signed [17:0] cy;
  logic signed [26:0] ang;
  logic               cneg;
  logic signed [17:0] dx;
  logic signed [17:0] dy;
  logic signed [26:0] at;

  always_comb begin
    t_s      = $signed({2'b00, div_q[24:0]});
    ang0     = (t_s <= hfpr_pkg::TURN_HALF) ? -t_s : (hfpr_pkg::TURN_FULL - t_s);
    ang1     = ang0;
    fold_neg = 1'b0;
    if (ang1 > hfpr_pkg::TURN_QUARTER) begin
      ang1     = ang1 - hfpr_pkg::TURN_HALF;
      fold_neg = 1'b1;
    end
    if (ang1 < -hfpr_pkg::TURN_QUARTER) begin
      ang1     = ang1 + hfpr_pkg::TURN_HALF;
      fold_neg = 1'b1;
    end
    dx = cy >>> cnt[3:0];
    dy = cx >>> cnt[3:0];
    at = $signed({5'b00000, hfpr_pkg::atan_turn(cnt[3:0])});
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_rot) begin
      cx   <= hfpr_pkg::CORDIC_X0;
      cy   <= '0;
      ang  <= ang1;
      cneg <= fold_neg;
    end else if (cmd.cordic_step) begin
      if (ang >= 0) begin
        cx  <= cx - dx;
        cy  <= cy + dy;
        ang <= ang - at;
      end else begin
        cx  <= cx + dx;
        cy  <= cy - dy;
        ang <= ang + at;
      end
    end
  end

  // twiddle in Q1.15, clamped
  logic signed [17:0] cf;
  logic signed [17:0] sf;
  logic signed [15:0] tw_c;
  logic signed [15:0] tw_s;

  always_comb begin
    cf = cneg ? -cx : cx;
    sf = cneg ? -cy : cy;
    if (cf > 18'sd32767)       tw_c = 16'sh7FFF;
    else if (cf < -18'sd32768) tw_c = 16'sh8000;
    else                       tw_c = cf[15:0];
    if (sf > 18'sd32767)       tw_s = 16'sh7FFF;
    else if (sf < -18'sd32768) tw_s = 16'sh8000;
    else                       tw_s = sf[15:0];
  end

  // complex multiply, one partial product per cycle
  logic signed [31:0] mul_a;
  logic signed [15:0] mul_b;
  logic signed [47:0] mul_p;
  logic signed [49:0] mul_px;
  logic signed [49:0] acc_re;
  logic signed [49:0] acc_im;

  always_comb begin
    case (cnt[1:0])
      2'd0:    begin mul_a = weight_re; mul_b = tw_c; end
      2'd1:    begin mul_a = weight_im; mul_b = tw_s; end
      2'd2:    begin mul_a = weight_re; mul_b = tw_s; end
      default: begin mul_a = weight_im; mul_b = tw_c; end
    endcase
    mul_p  = mul_a * mul_b;
    mul_px = {{2{mul_p[47]}}, mul_p};
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_step) begin
      case (cnt[1:0])
        2'd0:    acc_re <= mul_px;
        2'd1:    acc_re <= acc_re - mul_px;
        2'd2:    acc_im <= mul_px;
        default: acc_im <= acc_im + mul_px;
      endcase
    end
  end

  // round half up, shift, saturate
  logic signed [49:0] rnd_re;
  logic signed [49:0] rnd_im;
  logic signed [31:0] rot_re;
  logic signed [31:0] rot_im;

  always_comb begin
    rnd_re = (acc_re + 50'sd16384) >>> 15;
    rnd_im = (acc_im + 50'sd16384) >>> 15;
    if (rnd_re > 50'sd2147483647)       rot_re = 32'sh7FFFFFFF;
    else if (rnd_re < -50'sd2147483648) rot_re = 32'sh80000000;
    else                                rot_re = rnd_re[31:0];
    if (rnd_im > 50'sd2147483647)       rot_im = 32'sh7FFFFFFF;
    else if (rnd_im < -50'sd2147483648) rot_im = 32'sh80000000;
    else                                rot_im = rnd_im[31:0];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit_addr || cmd.emit_wt) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_addr) begin
      m_tdata <= {3'b000, kept_count, 32'd0, 32'd0, elem_addr};
      m_tuser <= hfpr_pkg::RES_ADDR;
      m_tlast <= 1'b0;
    end else if (cmd.emit_wt) begin
      m_tdata <= {3'b000, kept_count, rot_im, rot_re, 12'd0};
      m_tuser <= hfpr_pkg::RES_WEIGHT;
      m_tlast <= 1'b1;
    end
  end

  always_comb begin
    stat.elem_pinned = elem_pinned;
    stat.elem_last   = elem_last;
    stat.div_last    = cmd.div_step && step_last;
    stat.cordic_last = cmd.cordic_step && step_last;
    stat.mul_last    = cmd.mul_step && step_last;
    stat.out_free    = !m_tvalid || m_tready;
  end

endmodule

// ----- hdl/hint_fold_phase_rotator.sv -----
// ----------------------------------------------------------------------------
// hint_fold_phase_rotator
// Pins secret coordinates from hints, folds pinned coordinates of each sample
// into a phase and rotates the sample weight by minus that phase.
// ----------------------------------------------------------------------------
// One transaction at a time. A hint passes through the pin update state, a
// clear or an unknown action ends as it is taken in, and a sample element
// passes through the fold state and, if its address is passed on, an emit
// state that waits while m_tready holds the output register. The element with
// tlast then closes the sample: the bit-serial divider forms phase mod p and
// the fraction r*2^24/p, then 16 CORDIC rotations and 4 partial products on
// the single 32x16 multiplier form the rotated weight, with load and emit
// steps between. Pin values sit in a MAX_COORDS-deep RAM with registered read;
// pin flags are flops, so reset and the clear action take effect at once. A
// result waits in the output register while the next transaction is taken in.
module hint_fold_phase_rotator #(
  parameter int MAX_COORDS   = 256,
  parameter int RESIDUE_BITS = 12
) (
  input  logic         clk,
  input  logic         rst,
  // config write port: 0 modulus, 1 num_coords, 2 conf_threshold
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  // input stream
  input  logic         s_tvalid,
  output logic         s_tready,
  // hint_coord[7:0] hint_modulus[19:8] hint_value[31:20]
  // hint_confidence[47:32] elem_addr[59:48] weight_re[91:60] weight_im[123:92]
  input  logic [127:0] s_tdata,
  // action[1:0] hint_kind[3:2]
  input  logic [3:0]   s_tuser,
  input  logic         s_tlast,   // elem_last
  // output stream
  output logic         m_tvalid,
  input  logic         m_tready,
  // kept_addr[11:0] rot_re[43:12] rot_im[75:44] kept_count[84:76]
  output logic [87:0]  m_tdata,
  output logic         m_tuser,   // result_kind
  output logic         m_tlast    // last_of_sample
);

  hfpr_pkg::cmd_t  cmd;
  hfpr_pkg::stat_t stat;

  hfpr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_action (s_tuser[1:0]),
    .stat     (stat),
    .s_tready (s_tready),
    .cmd      (cmd)
  );

  hfpr_dp #(
    .MAX_COORDS   (MAX_COORDS),
    .RESIDUE_BITS (RESIDUE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .cmd       (cmd),
    .stat      (stat),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

// ----- hdl/hfpr_checker.sv -----
// ----------------------------------------------------------------------------
// hfpr_props
// Port-level checks on the result stream of the hint fold phase rotator.
// ----------------------------------------------------------------------------
module hfpr_props (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [87:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  // held result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  // tlast marks exactly the rotated-weight results
  a_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tuser == hfpr_pkg::RES_WEIGHT)))
    else $error("tlast does not match result kind");

  // address results carry no weight bits
  a_addr: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == hfpr_pkg::RES_ADDR) |-> (m_tdata[75:12] == 64'd0))
    else $error("address result carries weight bits");

  // at least one coordinate is always kept
  a_kept: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[84:76] != 9'd0))
    else $error("kept count is zero");

  // nothing is offered right after reset
  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind hint_fold_phase_rotator hfpr_props u_hfpr_props (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
